// ----- hw/rtl/point_segment_distance_top_assert.svh -----
// Assertion macros for the point/segment distance block.
// All checks sample on the rising edge of clk and are off while arst_n is low.
`ifndef POINT_SEGMENT_DISTANCE_TOP_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_TOP_ASSERT_SVH

// Condition that must hold at every sampled edge.
`define PSD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent at one edge requires the consequent at the next edge.
`define PSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/psd_pkg.sv -----
`default_nettype none
package psd_pkg;

	localparam int PSD_COORD_WIDTH = 16;
	localparam int PSD_FRAC_BITS   = 8;
	localparam int PSD_DIST_WIDTH  = 25;
	localparam logic [PSD_DIST_WIDTH-1:0] PSD_DIST_MAX = '1;

	typedef enum logic [1:0] {
		PSD_PART_INTERIOR = 2'd0,
		PSD_PART_START    = 2'd1,
		PSD_PART_END      = 2'd2
	} psd_part_t;

	// travels with every item down the pipeline
	typedef struct packed {
		logic      valid;
		psd_part_t part;
	} psd_tag_t;

endpackage
`default_nettype wire

// ----- hw/rtl/psd_query_if.sv -----
`default_nettype none
interface psd_query_if
	import psd_pkg::*;
	#(parameter int COORD_WIDTH = PSD_COORD_WIDTH) ();

	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] start_x;
	logic signed [COORD_WIDTH-1:0] start_y;
	logic signed [COORD_WIDTH-1:0] end_x;
	logic signed [COORD_WIDTH-1:0] end_y;

	modport source (output valid, point_x, point_y, start_x, start_y, end_x, end_y,
		input ready);
	modport sink (input valid, point_x, point_y, start_x, start_y, end_x, end_y,
		output ready);

endinterface
`default_nettype wire

// ----- hw/rtl/psd_result_if.sv -----
`default_nettype none
interface psd_result_if
	import psd_pkg::*;
	();

	logic                      valid;
	logic                      ready;
	logic [PSD_DIST_WIDTH-1:0] distance;
	logic [1:0]                nearest_part;

	modport source (output valid, distance, nearest_part, input ready);
	modport sink (input valid, distance, nearest_part, output ready);

endinterface
`default_nettype wire

// ----- hw/rtl/point_segment_distance_top.sv -----
`default_nettype none
// Channel  Role    Payload
// query    sink    point_x/y, start_x/y, end_x/y (COORD_WIDTH signed each)
// result   source  distance (25b, FRAC_BITS fraction bits), nearest_part (2b)
//
// One item per cycle sustained while result.ready is high. An accepted item
// passes the front stages, the divider cell chain (QW cells) and the root cell
// chain (RW cells), QW = 2*COORD_WIDTH+1+2*FRAC_BITS, RW = ceil(QW/2).
// arst_n clears every valid bit; payload registers are not reset.
// A stalled result holds in the output register; the pipeline keeps moving
// until an item reaches the last root cell, then query.ready drops.
module point_segment_distance_top
	import psd_pkg::*;
	#(
		parameter int COORD_WIDTH = PSD_COORD_WIDTH,
		parameter int FRAC_BITS   = PSD_FRAC_BITS
	) (
		input  wire logic    clk,
		input  wire logic    arst_n,
		psd_query_if.sink    query,
		psd_result_if.source result
	);

	localparam int LW = 2*COORD_WIDTH + 1;          // divisor (squared length)
	localparam int CW = 2*COORD_WIDTH + 1;          // cross product magnitude
	localparam int NW = 2*CW + 2*FRAC_BITS;         // dividend
	localparam int QW = 2*COORD_WIDTH + 1 + 2*FRAC_BITS; // quotient, root input
	localparam int RW = (QW + 1) / 2;               // root width
	localparam int EW = (RW > PSD_DIST_WIDTH) ? RW : PSD_DIST_WIDTH;

	// Shared stall: everything shifts unless the last root cell holds an item
	// that the full, stalled output register cannot take.
	logic en;
	logic out_load;

	psd_tag_t      ftag;
	logic [NW-1:0] fnum;
	logic [LW-1:0] fden;

	// divider chain taps
	psd_tag_t      dtag [QW+1];
	logic [LW-1:0] drem [QW+1];
	logic [QW-1:0] dnq  [QW+1];
	logic [LW-1:0] dden [QW+1];

	// root chain taps
	psd_tag_t        stag  [RW+1];
	logic [2*RW-1:0] srad  [RW+1];
	logic [RW+1:0]   srem  [RW+1];
	logic [RW-1:0]   sroot [RW+1];

	logic                      out_valid_q;
	logic [PSD_DIST_WIDTH-1:0] dist_q;
	psd_part_t                 part_q;
	logic [EW-1:0]             root_ext;
	logic [PSD_DIST_WIDTH-1:0] dist_c;

	assign out_load    = !out_valid_q || result.ready;
	assign en          = out_load || !stag[RW].valid;
	assign query.ready = en;

	psd_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(query.valid),
		.point_x (query.point_x),
		.point_y (query.point_y),
		.start_x (query.start_x),
		.start_y (query.start_y),
		.end_x   (query.end_x),
		.end_y   (query.end_y),
		.tag_out (ftag),
		.num_out (fnum),
		.den_out (fden)
	);

	// Top dividend bits preload the remainder; they are below the divisor.
	assign dtag[0] = ftag;
	assign drem[0] = fnum[NW-1:QW];
	assign dnq[0]  = fnum[QW-1:0];
	assign dden[0] = fden;

	for (genvar i = 0; i < QW; i++) begin : g_div
		psd_div_cell #(
			.LW(LW),
			.QW(QW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.tag_in (dtag[i]),
			.rem_in (drem[i]),
			.nq_in  (dnq[i]),
			.den_in (dden[i]),
			.tag_out(dtag[i+1]),
			.rem_out(drem[i+1]),
			.nq_out (dnq[i+1]),
			.den_out(dden[i+1])
		);
	end

	// Quotient (or the passed-through end-point square) feeds the root chain.
	assign stag[0]  = dtag[QW];
	assign srad[0]  = (2*RW)'(dnq[QW]);
	assign srem[0]  = '0;
	assign sroot[0] = '0;

	for (genvar j = 0; j < RW; j++) begin : g_sqrt
		psd_sqrt_cell #(
			.RW(RW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.tag_in  (stag[j]),
			.rad_in  (srad[j]),
			.rem_in  (srem[j]),
			.root_in (sroot[j]),
			.tag_out (stag[j+1]),
			.rad_out (srad[j+1]),
			.rem_out (srem[j+1]),
			.root_out(sroot[j+1])
		);
	end

	// saturate to the 25-bit field
	always_comb begin
		root_ext = EW'(sroot[RW]);
		dist_c   = (root_ext > EW'(PSD_DIST_MAX)) ? PSD_DIST_MAX
			: root_ext[PSD_DIST_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= stag[RW].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			dist_q <= dist_c;
			part_q <= stag[RW].part;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.distance     = dist_q;
	assign result.nearest_part = part_q;

endmodule
`default_nettype wire

// ----- hw/rtl/psd_front.sv -----
`default_nettype none
// Five stages: differences, products, sums, classify + partial squares, operand select.
module psd_front
	import psd_pkg::*;
	#(
		parameter int COORD_WIDTH = PSD_COORD_WIDTH,
		parameter int FRAC_BITS   = PSD_FRAC_BITS,
		localparam int LW = 2*COORD_WIDTH + 1,
		localparam int CW = 2*COORD_WIDTH + 1,
		localparam int NW = 2*CW + 2*FRAC_BITS
	) (
		input  wire logic                          clk,
		input  wire logic                          arst_n,
		input  wire logic                          en,
		input  wire logic                          in_valid,
		input  wire logic signed [COORD_WIDTH-1:0] point_x,
		input  wire logic signed [COORD_WIDTH-1:0] point_y,
		input  wire logic signed [COORD_WIDTH-1:0] start_x,
		input  wire logic signed [COORD_WIDTH-1:0] start_y,
		input  wire logic signed [COORD_WIDTH-1:0] end_x,
		input  wire logic signed [COORD_WIDTH-1:0] end_y,
		output psd_tag_t                           tag_out,
		output logic [NW-1:0]                      num_out,
		output logic [LW-1:0]                      den_out
	);

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2*COORD_WIDTH + 2;
	localparam int KW = (CW + 1) / 2;
	localparam int HW = CW - KW;
	localparam int SH = 2*FRAC_BITS;

	logic v_s1, v_s2, v_s3;
	psd_tag_t tag_s4, tag_s5;

	logic signed [DW-1:0] ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;
	logic signed [PW-1:0] bb_s2, yy_s2, axbx_s2, ayby_s2, axby_s2, aybx_s2;
	logic signed [PW-1:0] axax_s2, ayay_s2, cxcx_s2, cycy_s2;
	logic [LW-1:0]        len2_s3, ds_s3, de_s3;
	logic signed [PW-1:0] dot_s3;
	logic [CW-1:0]        cr_s3;
	logic [2*HW-1:0]      hh_s4;
	logic [HW+KW-1:0]     hl_s4;
	logic [2*KW-1:0]      ll_s4;
	logic [LW-1:0]        len2_s4, v_s4;
	logic [NW-1:0]        num_s5;
	logic [LW-1:0]        den_s5;

	logic signed [PW:0]   cr_c;
	logic [PW:0]          crabs_c;
	logic                 interior_c;
	psd_part_t            part_c;
	logic [LW-1:0]        v_c;
	logic [NW-1:0]        sq_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			tag_s4 <= '{valid: 1'b0, part: PSD_PART_INTERIOR};
			tag_s5 <= '{valid: 1'b0, part: PSD_PART_INTERIOR};
		end else if (en) begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			tag_s4 <= '{valid: v_s3, part: part_c};
			tag_s5 <= tag_s4;
		end
	end

	// cross product magnitude, the interior test, nearest-part choice and the cr^2 sum
	always_comb begin
		cr_c       = (PW+1)'(axby_s2) - (PW+1)'(aybx_s2);
		crabs_c    = cr_c[PW] ? $unsigned(-cr_c) : $unsigned(cr_c);
		interior_c = (len2_s3 != '0) && (dot_s3 > 0) && (dot_s3 < $signed({1'b0, len2_s3}));
		if (interior_c) begin
			part_c = PSD_PART_INTERIOR;
			v_c    = ds_s3;
		end else if ((len2_s3 == '0) || (ds_s3 <= de_s3)) begin
			part_c = PSD_PART_START;
			v_c    = ds_s3;
		end else begin
			part_c = PSD_PART_END;
			v_c    = de_s3;
		end
		sq_c = (NW'(hh_s4) << (2*KW + SH)) + (NW'(hl_s4) << (KW + 1 + SH))
			+ (NW'(ll_s4) << SH);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= DW'(point_x) - DW'(start_x);
			ay_s1 <= DW'(point_y) - DW'(start_y);
			bx_s1 <= DW'(end_x) - DW'(start_x);
			by_s1 <= DW'(end_y) - DW'(start_y);
			cx_s1 <= DW'(point_x) - DW'(end_x);
			cy_s1 <= DW'(point_y) - DW'(end_y);

			bb_s2   <= bx_s1 * bx_s1;
			yy_s2   <= by_s1 * by_s1;
			axbx_s2 <= ax_s1 * bx_s1;
			ayby_s2 <= ay_s1 * by_s1;
			axby_s2 <= ax_s1 * by_s1;
			aybx_s2 <= ay_s1 * bx_s1;
			axax_s2 <= ax_s1 * ax_s1;
			ayay_s2 <= ay_s1 * ay_s1;
			cxcx_s2 <= cx_s1 * cx_s1;
			cycy_s2 <= cy_s1 * cy_s1;

			len2_s3 <= LW'(bb_s2 + yy_s2);
			dot_s3  <= axbx_s2 + ayby_s2;
			cr_s3   <= crabs_c[CW-1:0];
			ds_s3   <= LW'(axax_s2 + ayay_s2);
			de_s3   <= LW'(cxcx_s2 + cycy_s2);

			// cr^2 split in halves: hi*hi, hi*lo, lo*lo
			hh_s4   <= cr_s3[CW-1:KW] * cr_s3[CW-1:KW];
			hl_s4   <= cr_s3[CW-1:KW] * cr_s3[KW-1:0];
			ll_s4   <= cr_s3[KW-1:0] * cr_s3[KW-1:0];
			len2_s4 <= len2_s3;
			v_s4    <= v_c;

			// end-point case divides by one so the divider passes it through
			if (tag_s4.part == PSD_PART_INTERIOR) begin
				num_s5 <= sq_c;
				den_s5 <= len2_s4;
			end else begin
				num_s5 <= NW'(v_s4) << SH;
				den_s5 <= LW'(1);
			end
		end
	end

	assign tag_out = tag_s5;
	assign num_out = num_s5;
	assign den_out = den_s5;

endmodule
`default_nettype wire

// ----- hw/rtl/psd_div_cell.sv -----
`default_nettype none
// One restoring division step: one quotient bit per cell.
module psd_div_cell
	import psd_pkg::*;
	#(
		parameter int LW = 33,
		parameter int QW = 49
	) (
		input  wire logic           clk,
		input  wire logic           arst_n,
		input  wire logic           en,
		input  wire psd_tag_t       tag_in,
		input  wire logic [LW-1:0]  rem_in,
		input  wire logic [QW-1:0]  nq_in,
		input  wire logic [LW-1:0]  den_in,
		output psd_tag_t            tag_out,
		output logic [LW-1:0]       rem_out,
		output logic [QW-1:0]       nq_out,
		output logic [LW-1:0]       den_out
	);

	logic [LW:0]   trial_c;
	logic [LW:0]   diff_c;
	logic          ge_c;
	psd_tag_t      tag_q;
	logic [LW-1:0] rem_q, den_q;
	logic [QW-1:0] nq_q;

	always_comb begin
		trial_c = {rem_in, nq_in[QW-1]};
		diff_c  = trial_c - {1'b0, den_in};
		ge_c    = trial_c >= {1'b0, den_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '{valid: 1'b0, part: PSD_PART_INTERIOR};
		end else if (en) begin
			tag_q <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge_c ? diff_c[LW-1:0] : trial_c[LW-1:0];
			nq_q  <= {nq_in[QW-2:0], ge_c};
			den_q <= den_in;
		end
	end

	assign tag_out = tag_q;
	assign rem_out = rem_q;
	assign nq_out  = nq_q;
	assign den_out = den_q;

endmodule
`default_nettype wire

// ----- hw/rtl/psd_sqrt_cell.sv -----
`default_nettype none
// One digit-by-digit square root step: one root bit per cell.
module psd_sqrt_cell
	import psd_pkg::*;
	#(
		parameter int RW = 25
	) (
		input  wire logic            clk,
		input  wire logic            arst_n,
		input  wire logic            en,
		input  wire psd_tag_t        tag_in,
		input  wire logic [2*RW-1:0] rad_in,
		input  wire logic [RW+1:0]   rem_in,
		input  wire logic [RW-1:0]   root_in,
		output psd_tag_t             tag_out,
		output logic [2*RW-1:0]      rad_out,
		output logic [RW+1:0]        rem_out,
		output logic [RW-1:0]        root_out
	);

	logic [RW+1:0]   cur_c, trial_c;
	logic            ge_c;
	psd_tag_t        tag_q;
	logic [2*RW-1:0] rad_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q;

	always_comb begin
		cur_c   = {rem_in[RW-1:0], rad_in[2*RW-1 -: 2]};
		trial_c = {root_in, 2'b01};
		ge_c    = cur_c >= trial_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '{valid: 1'b0, part: PSD_PART_INTERIOR};
		end else if (en) begin
			tag_q <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= rad_in << 2;
			rem_q  <= ge_c ? (cur_c - trial_c) : cur_c;
			root_q <= {root_in[RW-2:0], ge_c};
		end
	end

	assign tag_out  = tag_q;
	assign rad_out  = rad_q;
	assign rem_out  = rem_q;
	assign root_out = root_q;

endmodule
`default_nettype wire

// ----- hw/rtl/psd_checker.sv -----
`default_nettype none
`include "point_segment_distance_top_assert.svh"
module psd_checker
	import psd_pkg::*;
	(
		input wire logic                      clk,
		input wire logic                      arst_n,
		input wire logic                      in_ready,
		input wire logic                      out_valid,
		input wire logic                      out_ready,
		input wire logic [PSD_DIST_WIDTH-1:0] distance,
		input wire logic [1:0]                nearest_part
	);

	// a stalled result keeps its valid and payload
	`PSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(distance) && $stable(nearest_part), "result changed while stalled")

	// only three part codes exist
	`PSD_ASSERT_ALWAYS(a_part_code, !out_valid || nearest_part == PSD_PART_INTERIOR || nearest_part == PSD_PART_START || nearest_part == PSD_PART_END, "bad nearest_part code")

	// input backpressure only comes from a held, untaken result
	`PSD_ASSERT_ALWAYS(a_ready_cause, in_ready || (out_valid && !out_ready), "query stalled without output stall")

	// under a full stall the input stays blocked until the result is taken
	`PSD_ASSERT_NEXT(a_stall_keeps, !in_ready && !out_ready, !in_ready || out_ready, "pipeline moved under full stall")

endmodule

bind point_segment_distance_top psd_checker u_psd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (query.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.distance    (result.distance),
	.nearest_part(result.nearest_part)
);
`default_nettype wire

// ----- tb/sv/point_segment_distance_top_tb.sv -----
`timescale 1ns / 1ps
module point_segment_distance_top_tb;
	import psd_pkg::*;

	localparam int CW          = PSD_COORD_WIDTH;
	localparam int FB          = PSD_FRAC_BITS;
	localparam int LATENCY     = 6 + (2*CW+1+2*FB) + (2*CW+1+2*FB+1)/2;
	localparam int CYCLE_LIMIT = 400000;

	// one query item as it goes into the block
	typedef struct {
		logic signed [CW-1:0] px, py, sx, sy, ex, ey;
	} query_t;

	// one expected result item
	typedef struct {
		logic [PSD_DIST_WIDTH-1:0] dist_fp;
		psd_part_t                 part;
	} dist_t;

	logic clk;
	logic arst_n;
	bit   idle_en;
	int   errors;
	int   cycles;
	int   stall_left;
	dist_t expected_q[$];

	psd_query_if  query_ch();
	psd_result_if result_ch();

	point_segment_distance_top u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.query (query_ch),
		.result(result_ch)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// floor(sqrt(n)), digit by digit over the full 128-bit range
	function automatic logic [127:0] int_sqrt(input logic [127:0] n);
		logic [127:0] x, r, b;
		x = n;
		r = '0;
		b = 128'd1 << 126;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// exact distance from the point to the segment, floored fixed point
	function automatic dist_t predict_distance(input query_t q);
		longint ax, ay, bx, by, cx, cy, len2, dot, cr, ds, de;
		logic [127:0] wide_cr, num, d;
		dist_t o;
		ax = longint'(q.px) - longint'(q.sx);
		ay = longint'(q.py) - longint'(q.sy);
		bx = longint'(q.ex) - longint'(q.sx);
		by = longint'(q.ey) - longint'(q.sy);
		cx = longint'(q.px) - longint'(q.ex);
		cy = longint'(q.py) - longint'(q.ey);
		len2 = bx*bx + by*by;
		dot  = ax*bx + ay*by;
		if (len2 != 0 && dot > 0 && dot < len2) begin
			// projection falls strictly inside: perpendicular distance
			cr = ax*by - ay*bx;
			if (cr < 0) cr = -cr;
			wide_cr = 128'(cr);
			num = (wide_cr * wide_cr) << (2*FB);
			d = int_sqrt(num / 128'(len2));
			o.part = PSD_PART_INTERIOR;
		end else begin
			ds = ax*ax + ay*ay;
			de = cx*cx + cy*cy;
			// zero-length segment and ties go to the start point
			if (len2 == 0 || ds <= de) begin
				d = int_sqrt(128'(ds) << (2*FB));
				o.part = PSD_PART_START;
			end else begin
				d = int_sqrt(128'(de) << (2*FB));
				o.part = PSD_PART_END;
			end
		end
		if (d > 128'(PSD_DIST_MAX)) d = 128'(PSD_DIST_MAX);
		o.dist_fp = d[PSD_DIST_WIDTH-1:0];
		return o;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// drive one query item at the falling edge and hold it until accepted
	task automatic send_query(input query_t q);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			query_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		query_ch.valid   = 1'b1;
		query_ch.point_x = q.px;
		query_ch.point_y = q.py;
		query_ch.start_x = q.sx;
		query_ch.start_y = q.sy;
		query_ch.end_x   = q.ex;
		query_ch.end_y   = q.ey;
		do @(posedge clk); while (!query_ch.ready);
		expected_q.push_back(predict_distance(q));
		@(negedge clk);
		query_ch.valid = 1'b0;
	endtask

	function automatic query_t make_query(input int px, py, sx, sy, ex, ey);
		query_t q;
		q.px = px[CW-1:0];
		q.py = py[CW-1:0];
		q.sx = sx[CW-1:0];
		q.sy = sy[CW-1:0];
		q.ex = ex[CW-1:0];
		q.ey = ey[CW-1:0];
		return q;
	endfunction

	function automatic int rand_coord();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// random item, mostly shaped to land near the interesting boundaries
	function automatic query_t rand_query();
		query_t q;
		int cxo, cyo, dx, dy, k, kind;
		kind = $urandom_range(0, 9);
		cxo  = int'($urandom_range(0, 32000)) - 16000;
		cyo  = int'($urandom_range(0, 32000)) - 16000;
		dx   = int'($urandom_range(0, 200)) - 100;
		dy   = int'($urandom_range(0, 200)) - 100;
		k    = int'($urandom_range(0, 40)) - 20;
		case (kind)
			0, 1, 2: begin
				q = make_query(rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), rand_coord());
			end
			3: begin
				// zero-length segment
				q = make_query(rand_coord(), rand_coord(), cxo, cyo, cxo, cyo);
			end
			4: begin
				// projection exactly on the start point
				q = make_query(cxo - k*dy, cyo + k*dx, cxo, cyo, cxo + dx, cyo + dy);
			end
			5: begin
				// projection exactly on the end point
				q = make_query(cxo + dx - k*dy, cyo + dy + k*dx, cxo, cyo,
					cxo + dx, cyo + dy);
			end
			6: begin
				// point on the line through the segment
				q = make_query(cxo + k*dx, cyo + k*dy, cxo, cyo, cxo + dx, cyo + dy);
			end
			default: begin
				// small local geometry
				q = make_query(cxo + int'($urandom_range(0, 300)) - 150,
					cyo + int'($urandom_range(0, 300)) - 150,
					cxo, cyo, cxo + dx, cyo + dy);
			end
		endcase
		return q;
	endfunction

	task automatic test_directed();
		idle_en = 1'b1;
		send_query(make_query(0, 0, 0, 0, 0, 0));
		send_query(make_query(-32768, -32768, 32767, 32767, 32767, 32767));
		send_query(make_query(32767, 32767, -32768, -32768, -32768, -32768));
		send_query(make_query(-32768, 32767, 32767, -32768, 32767, 32767));
		send_query(make_query(32767, -32768, -32768, 32767, 32767, 32767));
		send_query(make_query(-32768, -32768, -32768, 32767, 32767, -32768));
		send_query(make_query(32767, 32767, -32768, 32767, 32767, -32768));
		send_query(make_query(0, 32767, -32768, -32768, 32767, -32768));
		send_query(make_query(5, 7, 0, 0, 10, 0));
		send_query(make_query(-3, 4, 0, 0, 10, 0));
		send_query(make_query(13, -4, 0, 0, 10, 0));
		send_query(make_query(0, 9, 0, 0, 10, 0));
		send_query(make_query(10, 9, 0, 0, 10, 0));
		send_query(make_query(4, 0, 0, 0, 10, 0));
		send_query(make_query(1, 1, 0, 0, 3, 3));
		send_query(make_query(2, 3, -1, -1, -1, -1));
		send_query(make_query(-20, 0, 0, 0, 10, 0));
		send_query(make_query(1, 0, 0, 0, 1, 1));
		send_query(make_query(32767, 32767, 32767, 32767, -32768, -32768));
		send_query(make_query(-1, -1, -1, -1, -1, -1));
	endtask

	task automatic test_random_idle();
		idle_en = 1'b1;
		repeat (560) send_query(rand_query());
	endtask

	task automatic test_random_streaming();
		// back to back on both sides
		idle_en = 1'b0;
		repeat (140) send_query(rand_query());
	endtask

	// result side ready, stalling in bursts while idling is on
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready = 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ch.ready = 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 14);
			result_ch.ready = 1'b0;
		end else begin
			result_ch.ready = 1'b1;
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		dist_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("result item with nothing expected");
			end else begin
				want = expected_q.pop_front();
				if (result_ch.distance !== want.dist_fp)
					report_mismatch($sformatf("distance got %0d want %0d",
						result_ch.distance, want.dist_fp));
				if (result_ch.nearest_part !== want.part)
					report_mismatch($sformatf("nearest_part got %0d want %0d",
						result_ch.nearest_part, want.part));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		stall_left = 0;
		idle_en = 1'b0;
		arst_n = 1'b0;
		query_ch.valid   = 1'b0;
		query_ch.point_x = '0;
		query_ch.point_y = '0;
		query_ch.start_x = '0;
		query_ch.start_y = '0;
		query_ch.end_x   = '0;
		query_ch.end_y   = '0;
		result_ch.ready  = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_idle();
		test_random_streaming();

		// drain, then give the pipeline time to show any stray item
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/psd_pkg.sv
hw/rtl/psd_query_if.sv
hw/rtl/psd_result_if.sv
hw/rtl/psd_front.sv
hw/rtl/psd_div_cell.sv
hw/rtl/psd_sqrt_cell.sv
hw/rtl/point_segment_distance_top.sv
hw/rtl/psd_checker.sv
tb/sv/point_segment_distance_top_tb.sv
